// File: sv/fca_pkg.sv
// Shared types, constants and helpers of the file allocation table block.
package fca_pkg;

  // Width of one table entry and of the block indexes.
  localparam int unsigned ENT_W = 16;

  // Default table depth and configuration reset values.
  localparam int unsigned DEF_TABLE_DEPTH = 4096;
  localparam logic [ENT_W-1:0] FDB_RESET    = 16'd130;
  localparam logic [ENT_W-1:0] BCOUNT_RESET = 16'd4096;

  // Entry markers.
  localparam logic [ENT_W-1:0] ENT_FREE = 16'hFFFF;
  localparam logic [ENT_W-1:0] ENT_END  = 16'hFFFE;
  localparam logic [ENT_W-1:0] ENT_RSVD = 16'hFFFD;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FIRST_DATA_BLOCK = 1'b0,
    CFG_BLOCK_COUNT      = 1'b1
  } fca_cfg_idx_t;

  // Operation codes carried by the kind field.
  typedef enum logic [2:0] {
    K_FORMAT   = 3'd0,
    K_ALLOCATE = 3'd1,
    K_FREE     = 3'd2,
    K_LINK     = 3'd3,
    K_READ     = 3'd4,
    K_TRUNCATE = 3'd5
  } fca_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BOUND  = 2'd3
  } fca_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FORMAT,
    S_ALLOC,
    S_WALK_RD,
    S_WALK_WR,
    S_TAIL_END,
    S_READ_WAIT,
    S_DONE
  } fca_state_t;

  // Payload of one command item.
  typedef struct packed {
    logic [2:0]       kind;
    logic [ENT_W-1:0] block_index;
    logic [ENT_W-1:0] link_value;
    logic [ENT_W-1:0] keep_blocks;
  } fca_cmd_t;

  // Payload of one result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [ENT_W-1:0] result_block;
    logic [ENT_W-1:0] freed_count;
  } fca_res_t;

  // A chain ends at the end marker or at a free entry.
  function automatic logic is_end(input logic [ENT_W-1:0] v);
    return (v == ENT_END) || (v == ENT_FREE);
  endfunction

endpackage

// File: sv/fca_stream_if.sv
// Valid/ready stream interface with a typed payload.
interface fca_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/fca_table_ram.sv
// Single-clock table memory with one write port and one registered read port.
module fca_table_ram
  import fca_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data valid in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/fat_chain_allocator.sv
// Top level of the 16-bit file allocation table with its operation sequencer.
//
// The block keeps a table of TABLE_DEPTH 16-bit entries in one synchronous memory and runs
// one item at a time through a small sequencer; every item yields one result item. Link,
// unknown kinds, a read next out of range and an allocate with no room at all go straight
// to the result, and read next in range waits for the registered table read. Format sweeps
// the whole table. Allocate scans from the first data block and marks the first free entry
// it finds as a chain end. Free chain reads and then frees each chain entry visited. Truncate
// does the same after it steps over the kept part, and when it kept any block and a tail
// follows, it ends the kept part with an end-of-chain write. A new item is taken as soon as
// the previous result sits in the output register, even while that result waits to be taken.
// The table holds no defined contents until a format item has run. Configuration is to be
// written by the user through the cfg_ port only while the block is idle; the block itself
// does not enforce this.
module fat_chain_allocator
  import fca_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  fca_stream_if.sink          in_item,
  fca_stream_if.source        out_item,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [ENT_W-1:0]    cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [ENT_W-1:0] DEPTH_W = ENT_W'(TABLE_DEPTH);
  localparam logic [ENT_W-1:0] LAST_W  = ENT_W'(TABLE_DEPTH - 1);

  // Configuration registers.
  logic [ENT_W-1:0] fdb_r;
  logic [ENT_W-1:0] bcount_r;

  // Sequencer and working registers.
  fca_state_t       state_r, state_nxt;
  logic [ENT_W-1:0] keep_r, keep_nxt;
  logic [ENT_W-1:0] cur_r, cur_nxt;
  logic [AW-1:0]    prev_r, prev_nxt;
  logic [ENT_W-1:0] steps_r, steps_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic             keep_ph_r, keep_ph_nxt;
  logic             trunc_r, trunc_nxt;
  logic [ENT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  fca_status_t      status_r, status_nxt;
  logic [ENT_W-1:0] result_r, result_nxt;
  logic [ENT_W-1:0] freed_r, freed_nxt;

  // Output register.
  logic             out_valid_r;
  fca_res_t         out_data_r;

  // Table memory controls.
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  // Shared conditions.
  logic [ENT_W-1:0] cnt;
  logic             in_acc;
  logic             out_free;
  logic             idx_oor;
  logic             alloc_empty;
  logic             cur_is_end;
  logic             cur_oor;
  logic             at_bound;
  logic             keep_more;
  logic             hit;
  logic             scan_more;
  logic             fmt_last;
  logic             walk_stop;

  assign cnt         = (bcount_r < DEPTH_W) ? bcount_r : DEPTH_W;
  assign in_acc      = in_item.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_item.ready;
  assign idx_oor     = in_item.data.block_index >= cnt;
  assign alloc_empty = fdb_r >= cnt;
  assign cur_is_end  = is_end(cur_r);
  assign cur_oor     = cur_r >= cnt;
  assign at_bound    = steps_r >= DEPTH_W;
  assign keep_more   = steps_r < keep_r;
  assign hit         = pend_r && (mem_rdata == ENT_FREE);
  assign scan_more   = scan_r < cnt;
  assign fmt_last    = scan_r == LAST_W;
  assign walk_stop   = cur_is_end || cur_oor || at_bound;

  assign in_item.ready  = (state_r == S_IDLE);
  assign out_item.valid = out_valid_r;
  assign out_item.data  = out_data_r;

  // Table memory.
  fca_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdb_r    <= FDB_RESET;
      bcount_r <= BCOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_DATA_BLOCK: fdb_r    <= cfg_wdata;
        CFG_BLOCK_COUNT:      bcount_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item.data.kind)
            K_FORMAT:   state_nxt = S_FORMAT;
            K_ALLOCATE: state_nxt = alloc_empty ? S_DONE : S_ALLOC;
            K_FREE:     state_nxt = S_WALK_RD;
            K_TRUNCATE: state_nxt = S_WALK_RD;
            K_READ:     state_nxt = idx_oor ? S_DONE : S_READ_WAIT;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_FORMAT: begin
        if (fmt_last) state_nxt = S_DONE;
      end
      S_ALLOC: begin
        if (hit) state_nxt = S_DONE;
        else if (!scan_more && !pend_r) state_nxt = S_DONE;
      end
      S_WALK_RD: begin
        if (keep_ph_r) begin
          if (!keep_more || cur_is_end) begin
            state_nxt = cur_is_end ? S_DONE : S_WALK_RD;
          end else if (cur_oor || at_bound) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WALK_WR;
          end
        end else if (walk_stop) begin
          state_nxt = (trunc_r && have_prev_r) ? S_TAIL_END : S_DONE;
        end else begin
          state_nxt = S_WALK_WR;
        end
      end
      S_WALK_WR:   state_nxt = S_WALK_RD;
      S_TAIL_END:  state_nxt = S_DONE;
      S_READ_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and table access for each state.
  always_comb begin
    keep_nxt      = keep_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    have_prev_nxt = have_prev_r;
    keep_ph_nxt   = keep_ph_r;
    trunc_nxt     = trunc_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    result_nxt    = result_r;
    freed_nxt     = freed_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r[AW-1:0];
    mem_wdata     = ENT_FREE;
    mem_raddr     = cur_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          keep_nxt      = in_item.data.keep_blocks;
          cur_nxt       = in_item.data.block_index;
          steps_nxt     = '0;
          have_prev_nxt = 1'b0;
          keep_ph_nxt   = (in_item.data.kind == K_TRUNCATE);
          trunc_nxt     = (in_item.data.kind == K_TRUNCATE);
          scan_nxt      = (in_item.data.kind == K_FORMAT) ? '0 : fdb_r;
          pend_nxt      = 1'b0;
          status_nxt    = ST_OK;
          result_nxt    = '0;
          freed_nxt     = '0;
          mem_raddr     = in_item.data.block_index[AW-1:0];
          case (in_item.data.kind)
            K_ALLOCATE: begin
              if (alloc_empty) begin
                status_nxt = ST_NOFREE;
                result_nxt = ENT_FREE;
              end
            end
            K_LINK: begin
              if (idx_oor) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_item.data.block_index[AW-1:0];
                mem_wdata = in_item.data.link_value;
              end
            end
            K_READ: begin
              if (idx_oor) status_nxt = ST_RANGE;
            end
            default: ;
          endcase
        end
      end
      // Sweep the whole table: reserved below the first data block, free from it upward.
      S_FORMAT: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r[AW-1:0];
        mem_wdata = (scan_r < fdb_r) ? ENT_RSVD : ENT_FREE;
        scan_nxt  = scan_r + 1'b1;
      end
      // Issue one read per cycle and test the entry that comes back.
      S_ALLOC: begin
        mem_raddr = scan_r[AW-1:0];
        if (hit) begin
          mem_we     = 1'b1;
          mem_waddr  = pend_addr_r;
          mem_wdata  = ENT_END;
          result_nxt = ENT_W'(pend_addr_r);
          pend_nxt   = 1'b0;
        end else if (scan_more) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_r[AW-1:0];
          scan_nxt      = scan_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          status_nxt = ST_NOFREE;
          result_nxt = ENT_FREE;
        end
      end
      // Check the current chain entry and read its next value.
      S_WALK_RD: begin
        if (keep_ph_r) begin
          if (!keep_more || cur_is_end) begin
            keep_ph_nxt = 1'b0;
            steps_nxt   = '0;
          end else if (cur_oor) begin
            status_nxt = ST_RANGE;
          end else if (at_bound) begin
            status_nxt = ST_BOUND;
          end else begin
            prev_nxt      = cur_r[AW-1:0];
            have_prev_nxt = 1'b1;
          end
        end else if (!cur_is_end) begin
          if (cur_oor) status_nxt = ST_RANGE;
          else if (at_bound) status_nxt = ST_BOUND;
        end
      end
      // Follow the link; in the freeing phase also free the entry.
      S_WALK_WR: begin
        cur_nxt   = mem_rdata;
        steps_nxt = steps_r + 1'b1;
        if (!keep_ph_r) begin
          mem_we = 1'b1;
          if (mem_rdata != ENT_FREE) freed_nxt = freed_r + 1'b1;
        end
      end
      // End the kept part of a truncated chain.
      S_TAIL_END: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r;
        mem_wdata = ENT_END;
      end
      S_READ_WAIT: begin
        result_nxt = mem_rdata;
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    keep_r      <= keep_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    steps_r     <= steps_nxt;
    have_prev_r <= have_prev_nxt;
    keep_ph_r   <= keep_ph_nxt;
    trunc_r     <= trunc_nxt;
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    result_r    <= result_nxt;
    freed_r     <= freed_nxt;
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r.status       <= status_r;
      out_data_r.result_block <= result_r;
      out_data_r.freed_count  <= freed_r;
    end
  end

endmodule

// File: sv/fca_checker.sv
// Port-level checks of the file allocation table block, bound to its top level.
module fca_port_checks
  import fca_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input logic [ENT_W-1:0] out_result,
  input logic [ENT_W-1:0] out_freed
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // A result needs an item that is still open.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (open_r != 2'd0))
    else $error("result item without an open command item");

  // At most one item at work and one result waiting.
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= 2'd2)
    else $error("too many open items");

  // Every accepted item moves the sequencer out of idle, so ready drops after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready stayed high after an accepted item");

  // A failed allocation reports the free marker and frees nothing.
  a_nofree_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOFREE)) |-> ((out_result == ENT_FREE) && (out_freed == '0)))
    else $error("no-free result with wrong payload");

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result item dropped before it was taken");

endmodule

bind fat_chain_allocator fca_port_checks u_fca_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_item.valid),
  .in_ready   (in_item.ready),
  .out_valid  (out_item.valid),
  .out_ready  (out_item.ready),
  .out_status (out_item.data.status),
  .out_result (out_item.data.result_block),
  .out_freed  (out_item.data.freed_count)
);

// File: sim/fca_checker.sv
// Checker for the file allocation table: predicts each result from its own table copy.
module fca_checker
  import fca_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  logic             cmd_ready,
  input  fca_cmd_t         cmd_data,
  input  logic             res_valid,
  input  logic             res_ready,
  input  fca_res_t         res_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [ENT_W-1:0] cfg_wdata,
  output int unsigned      fail_count,
  output int unsigned      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the table and of the two registers.
  logic [ENT_W-1:0] fat_shadow [TABLE_DEPTH];
  logic [ENT_W-1:0] data_start;
  logic [ENT_W-1:0] entries_cfg;
  logic [ENT_W-1:0] freed_tally;
  fca_res_t         answers_due [$];
  fca_res_t         want;
  int unsigned      mismatches = 0;

  // Entries in use, clamped to the table depth.
  function automatic int unsigned live_entries();
    return (entries_cfg < TABLE_DEPTH) ? entries_cfg : TABLE_DEPTH;
  endfunction

  // A chain stops at the end marker or at a free entry.
  function automatic logic chain_stop(input logic [ENT_W-1:0] v);
    return (v == ENT_END) || (v == ENT_FREE);
  endfunction

  // Follows a chain and frees every entry on it; counts entries that were not free.
  function automatic fca_status_t release_chain(input logic [ENT_W-1:0] start);
    logic [ENT_W-1:0] cur;
    logic [ENT_W-1:0] nxt;
    int unsigned      steps;
    cur   = start;
    steps = 0;
    while (!chain_stop(cur)) begin
      if (cur >= live_entries()) return ST_RANGE;
      if (steps >= TABLE_DEPTH) return ST_BOUND;
      nxt = fat_shadow[cur];
      if (nxt != ENT_FREE) freed_tally = freed_tally + 1'b1;
      fat_shadow[cur] = ENT_FREE;
      cur = nxt;
      steps++;
    end
    return ST_OK;
  endfunction

  // Applies one command item to the shadow table and returns the result it must give.
  function automatic fca_res_t apply_cmd(input fca_cmd_t c);
    fca_res_t         r;
    int unsigned      n;
    int unsigned      k;
    int unsigned      steps;
    logic [ENT_W-1:0] cur;
    logic [ENT_W-1:0] prev;
    logic             have_prev;
    r           = '0;
    n           = live_entries();
    freed_tally = '0;
    case (c.kind)
      K_FORMAT: begin
        for (k = 0; k < TABLE_DEPTH; k++)
          fat_shadow[k] = (k < data_start) ? ENT_RSVD : ENT_FREE;
      end
      K_ALLOCATE: begin
        r.status       = ST_NOFREE;
        r.result_block = ENT_FREE;
        for (k = data_start; k < n; k++) begin
          if (fat_shadow[k] == ENT_FREE) begin
            fat_shadow[k]  = ENT_END;
            r.status       = ST_OK;
            r.result_block = k[ENT_W-1:0];
            break;
          end
        end
      end
      K_FREE: begin
        r.status = release_chain(c.block_index);
      end
      K_LINK: begin
        if (c.block_index >= n) r.status = ST_RANGE;
        else fat_shadow[c.block_index] = c.link_value;
      end
      K_READ: begin
        if (c.block_index >= n) r.status = ST_RANGE;
        else r.result_block = fat_shadow[c.block_index];
      end
      K_TRUNCATE: begin
        // Step over the kept blocks, then free the tail and close the chain.
        cur       = c.block_index;
        prev      = '0;
        have_prev = 1'b0;
        steps     = 0;
        for (k = 0; k < c.keep_blocks && !chain_stop(cur); k++) begin
          if (cur >= n) begin
            r.status = ST_RANGE;
            break;
          end
          if (steps >= TABLE_DEPTH) begin
            r.status = ST_BOUND;
            break;
          end
          prev      = cur;
          have_prev = 1'b1;
          cur       = fat_shadow[cur];
          steps++;
        end
        if (r.status == ST_OK && !chain_stop(cur)) begin
          r.status = release_chain(cur);
          if (have_prev) fat_shadow[prev] = ENT_END;
        end
      end
      default: begin
      end
    endcase
    r.freed_count = freed_tally;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [ENT_W-1:0] exp_v,
                             input logic [ENT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endtask

  // Track registers, predict at input acceptance, compare at result acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      data_start  = FDB_RESET;
      entries_cfg = BCOUNT_RESET;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (fca_cfg_idx_t'(cfg_index))
          CFG_FIRST_DATA_BLOCK: data_start = cfg_wdata;
          CFG_BLOCK_COUNT:      entries_cfg = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd_valid && cmd_ready) answers_due.push_back(apply_cmd(cmd_data));
      if (res_valid && res_ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected, expected nothing, actual %h",
                   $time, res_data);
        end else begin
          want = answers_due.pop_front();
          check_field("status", ENT_W'(want.status), ENT_W'(res_data.status));
          check_field("result_block", want.result_block, res_data.result_block);
          check_field("freed_count", want.freed_count, res_data.freed_count);
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= answers_due.size();
  end

endmodule

// File: sim/tb.sv
// Top of the testbench: stimulus, idling, configuration phases, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fca_pkg::*;

  localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned WINDOW      = 24;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned IDLE_LIGHT  = 38;
  localparam int unsigned IDLE_HEAVY  = 79;
  localparam int unsigned IDLE_NONE   = 0;
  // Kind codes with no operation behind them.
  localparam logic [2:0]  KIND_SPARE_A = 3'd6;
  localparam logic [2:0]  KIND_SPARE_B = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [ENT_W-1:0] cfg_wdata;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      items_sent;
  int unsigned      quiet_cycles = 0;
  int unsigned      fail_count;
  int unsigned      outstanding;
  logic [ENT_W-1:0] base_idx;

  fca_stream_if #(.T(fca_cmd_t)) cmd_ch ();
  fca_stream_if #(.T(fca_res_t)) res_ch ();

  fat_chain_allocator #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (cmd_ch),
    .out_item (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  fca_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_ch.valid),
    .cmd_ready  (cmd_ch.ready),
    .cmd_data   (cmd_ch.data),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .res_data   (res_ch.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL fat_chain_allocator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command item, with random idle cycles ahead of it.
  task automatic send_cmd(input logic [2:0] kind, input logic [ENT_W-1:0] idx,
                          input logic [ENT_W-1:0] lval, input logic [ENT_W-1:0] keep);
    fca_cmd_t c;
    c.kind        = kind;
    c.block_index = idx;
    c.link_value  = lval;
    c.keep_blocks = keep;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Waits for idle, writes both registers and formats the table.
  task automatic start_phase(input logic [ENT_W-1:0] fdb, input logic [ENT_W-1:0] count,
                             input int unsigned s_pct, input int unsigned r_pct);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_DATA_BLOCK;
    cfg_wdata <= fdb;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we        <= 1'b0;
    base_idx      = fdb;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    send_cmd(K_FORMAT, '0, '0, '0);
  endtask

  // An index near the first data block, where allocation and chains live.
  function automatic logic [ENT_W-1:0] window_idx();
    return base_idx + ENT_W'($urandom_range(0, WINDOW - 1));
  endfunction

  // Random traffic: in half of the draws, linked chains that are then read, cut and freed.
  task automatic run_mix(input int unsigned n);
    int unsigned      goal;
    int unsigned      roll;
    int unsigned      len;
    int unsigned      j;
    int unsigned      m;
    logic             dup;
    logic [2:0]       kind;
    logic [ENT_W-1:0] links [6];
    logic [ENT_W-1:0] nxt;
    logic [ENT_W-1:0] idx;
    logic [ENT_W-1:0] lval;
    logic [ENT_W-1:0] keep;
    goal = items_sent + n;
    while (items_sent < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_cmd(K_FORMAT, '0, '0, '0);
      end else if (roll < 52) begin
        // Build a chain of distinct blocks, sometimes closed into a loop.
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) begin
          do begin
            links[j] = window_idx();
            dup      = 1'b0;
            for (m = 0; m < j; m++) if (links[m] == links[j]) dup = 1'b1;
          end while (dup);
        end
        for (j = 0; j < len; j++) begin
          if (j + 1 < len) nxt = links[j + 1];
          else if ($urandom_range(0, 5) == 0) nxt = links[0];
          else if ($urandom_range(0, 7) == 0) nxt = ENT_FREE;
          else nxt = ENT_END;
          send_cmd(K_LINK, links[j], nxt, '0);
        end
        if ($urandom_range(0, 1) == 1)
          send_cmd(K_READ, links[$urandom_range(0, len - 1)], '0, '0);
        case ($urandom_range(0, 2))
          0: send_cmd(K_TRUNCATE, links[0], '0, ENT_W'($urandom_range(0, len + 1)));
          1: send_cmd(K_FREE, links[0], '0, '0);
          default: begin
            send_cmd(K_TRUNCATE, links[0], '0, ENT_W'($urandom_range(0, len)));
            send_cmd(K_FREE, links[0], '0, '0);
          end
        endcase
      end else if (roll < 85) begin
        // Single operation with fields biased toward the live region.
        m = $urandom_range(0, 99);
        if (m < 25) kind = K_ALLOCATE;
        else if (m < 40) kind = K_FREE;
        else if (m < 60) kind = K_LINK;
        else if (m < 80) kind = K_READ;
        else if (m < 95) kind = K_TRUNCATE;
        else kind = m[0] ? KIND_SPARE_A : KIND_SPARE_B;
        m = $urandom_range(0, 99);
        if (m < 85) idx = window_idx();
        else if (m < 95) idx = ENT_W'($urandom_range(0, 4200));
        else idx = ENT_W'($urandom);
        m = $urandom_range(0, 99);
        if (m < 40) lval = ENT_END;
        else if (m < 80) lval = window_idx();
        else if (m < 90) lval = m[0] ? ENT_FREE : ENT_RSVD;
        else lval = ENT_W'($urandom);
        if ($urandom_range(0, 9) != 0) keep = ENT_W'($urandom_range(0, 8));
        else keep = ENT_W'($urandom);
        send_cmd(kind, idx, lval, keep);
      end else begin
        // Noise over the whole field ranges.
        kind = 3'($urandom_range(1, 7));
        idx  = ENT_W'($urandom);
        lval = ENT_W'($urandom);
        keep = ENT_W'($urandom);
        send_cmd(kind, idx, lval, keep);
      end
    end
  endtask

  initial begin
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    res_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FIRST_DATA_BLOCK;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    items_sent    = 0;
    base_idx      = FDB_RESET;
    send_idle_pct = IDLE_LIGHT;
    recv_idle_pct = IDLE_HEAVY;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Small table: allocation, links, reads, range errors and chain walks.
    start_phase(16'd4, 16'd16, IDLE_LIGHT, IDLE_HEAVY);
    send_cmd(K_ALLOCATE, '0, '0, '0);
    send_cmd(K_ALLOCATE, '0, '0, '0);
    send_cmd(K_LINK, 16'd4, 16'd5, '0);
    // The chain ends on a free entry rather than the end marker.
    send_cmd(K_LINK, 16'd5, 16'd6, '0);
    send_cmd(K_READ, 16'd4, '0, '0);
    send_cmd(K_READ, 16'd15, '0, '0);
    send_cmd(K_READ, 16'd16, '0, '0);
    send_cmd(K_LINK, ENT_FREE, '0, '0);
    send_cmd(K_TRUNCATE, 16'd4, '0, 16'd1);
    send_cmd(K_FREE, 16'd4, '0, '0);
    send_cmd(K_FREE, ENT_END, '0, '0);
    // A walk that meets the reserved marker stops with a range error.
    send_cmd(K_LINK, 16'd8, ENT_RSVD, '0);
    send_cmd(K_FREE, 16'd8, '0, '0);
    // Truncate keeping nothing frees the whole chain.
    send_cmd(K_LINK, 16'd9, 16'd10, '0);
    send_cmd(K_LINK, 16'd10, ENT_END, '0);
    send_cmd(K_TRUNCATE, 16'd9, '0, '0);
    // A two-entry loop walked with the largest keep runs into the walk bound.
    send_cmd(K_LINK, 16'd11, 16'd12, '0);
    send_cmd(K_LINK, 16'd12, 16'd11, '0);
    send_cmd(K_TRUNCATE, 16'd11, '0, ENT_FREE);
    send_cmd(K_FREE, 16'd11, '0, '0);
    send_cmd(KIND_SPARE_A, ENT_FREE, ENT_FREE, ENT_FREE);
    send_cmd(KIND_SPARE_B, '0, '0, '0);
    send_cmd(K_READ, 16'd0, '0, '0);

    // Everything reserved: allocation has no room.
    start_phase(ENT_FREE, 16'd1, IDLE_LIGHT, IDLE_HEAVY);
    send_cmd(K_ALLOCATE, '0, '0, '0);

    // Count above the depth is clamped; tail errors still close the kept part.
    start_phase(16'd0, 16'd65533, IDLE_LIGHT, IDLE_HEAVY);
    send_cmd(K_ALLOCATE, '0, '0, '0);
    send_cmd(K_LINK, 16'd1, 16'd5000, '0);
    send_cmd(K_TRUNCATE, 16'd1, '0, 16'd2);
    send_cmd(K_LINK, 16'd2, 16'd3, '0);
    send_cmd(K_LINK, 16'd3, ENT_RSVD, '0);
    send_cmd(K_TRUNCATE, 16'd2, '0, 16'd1);
    send_cmd(K_READ, 16'd4096, '0, '0);

    // Random phases under several settings and idling patterns.
    start_phase(16'd130, 16'd4096, IDLE_LIGHT, IDLE_HEAVY);
    run_mix(PHASE_ITEMS);
    start_phase(16'd2, 16'd48, IDLE_HEAVY, IDLE_LIGHT);
    run_mix(PHASE_ITEMS);
    start_phase(16'd1, 16'd4095, IDLE_NONE, IDLE_NONE);
    run_mix(PHASE_ITEMS);
    start_phase(16'd4000, 16'd4090, IDLE_NONE, IDLE_NONE);
    run_mix(PHASE_ITEMS);

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS fat_chain_allocator");
    end else begin
      $display("FAIL fat_chain_allocator");
    end
    $finish;
  end

endmodule
